// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL of the token parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ATP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ATP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/atp_pkg.sv =====
package atp_pkg;

    localparam int MAG_W = 64;
    localparam int ACC_W = MAG_W + 4;

    localparam logic [MAG_W-1:0] MAG_TOP = {1'b1, {(MAG_W-1){1'b0}}};

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_BIN
    } radix_t;

    // One classified beat handed from the front end to the accumulator.
    typedef struct packed {
        logic       digit_en;
        logic [3:0] digit;
        radix_t     radix;
        logic       last;
        logic       shape_ok;
        logic       negative;
    } uop_t;

endpackage

// ===== hdl/ascii_int64_token_parser.sv =====
// Path: the beat that ends a token is queued as a command, accumulated and latched into the
// finishing stage, finished into the result queue, and then shows on the result side.
// Throughput: one input beat per cycle while the command queue is not full, set by the
// combinational scale-and-add of the accumulator; a two-entry queue sits on each side of it.
// Reset: rst_n is asynchronous and active low; it empties both queues and returns the
// parser to the start of a token with a zero magnitude.
module ascii_int64_token_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       ch,
    input  logic                             has_char,
    input  logic                             end_of_token,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [atp_pkg::MAG_W-1:0] value,
    output logic                             valid_res
);
    import atp_pkg::*;

    // The front end tracks the token's shape: sign, leading zero, radix prefix and
    // whether a character is illegal for the chosen base. None of this depends on the
    // magnitude, so it settles in the cycle the beat arrives and leaves behind only a
    // compact command: an optional digit plus, on the last beat, the shape verdict.
    uop_t uop_in;
    uop_t uop_head;
    logic uop_push;
    logic uop_empty;
    logic uop_pop;

    atp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .q_full       (full),
        .ch           (ch),
        .has_char     (has_char),
        .end_of_token (end_of_token),
        .uop_push     (uop_push),
        .uop          (uop_in)
    );

    // A short queue decouples the two halves, so a stall in the back end only stops
    // the front end once both entries are taken. The input side reports full from it.
    atp_uop_queue u_uop_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (uop_push),
        .wr_data (uop_in),
        .full    (full),
        .rd_en   (uop_pop),
        .empty   (uop_empty),
        .rd_data (uop_head)
    );

    // The back end keeps the 64-bit magnitude and the overflow flag. Each digit is a
    // shift-and-add by the base with an exact overflow test on the carry bits. The last
    // command of a token is latched into a finishing stage that applies the signed range
    // check and the negation, then writes the result into a two-entry result queue.
    atp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop_empty (uop_empty),
        .uop       (uop_head),
        .uop_pop   (uop_pop),
        .empty     (empty),
        .pop       (pop),
        .value     (value),
        .valid_res (valid_res)
    );

endmodule

// ===== hdl/atp_front.sv =====
module atp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          q_full,
    input  logic [7:0]    ch,
    input  logic          has_char,
    input  logic          end_of_token,
    output logic          uop_push,
    output atp_pkg::uop_t uop
);
    import atp_pkg::*;

    phase_t phase_reg, phase_next;
    radix_t radix_reg, radix_next;
    logic   neg_reg, neg_next;
    logic   bad_reg, bad_next;

    logic       accept;
    logic       is_dec;
    logic       is_alpha;
    logic [3:0] dig_val;
    logic       dig_ok;
    logic       digit_path;

    assign accept = push && !q_full;

    // Character class and digit value.
    always_comb
    begin
        is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_alpha = ((ch >= CH_LO_A) && (ch <= CH_LO_F)) ||
                   ((ch >= CH_UP_A) && (ch <= CH_UP_F));
        dig_val  = is_alpha ? (ch[3:0] + 4'd9) : ch[3:0];
        unique case (radix_reg)
            RADIX_HEX: dig_ok = is_dec || is_alpha;
            RADIX_BIN: dig_ok = (ch == CH_ZERO) || (ch == CH_ONE);
            default:   dig_ok = is_dec;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            radix_reg <= RADIX_DEC;
            neg_reg   <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            neg_reg   <= neg_next;
            bad_reg   <= bad_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        bad_next   = bad_reg;
        digit_path = 1'b0;

        if (accept && has_char && !bad_reg)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if ((ch == CH_PLUS) || (ch == CH_MINUS))
                    begin
                        neg_next   = (ch == CH_MINUS);
                        phase_next = PH_SIGN;
                    end
                    else if (ch == CH_ZERO)
                        phase_next = PH_ZERO;
                    else
                        digit_path = 1'b1;
                end
                PH_SIGN:
                begin
                    if (ch == CH_ZERO)
                        phase_next = PH_ZERO;
                    else
                        digit_path = 1'b1;
                end
                PH_ZERO:
                begin
                    if ((ch == CH_LO_X) || (ch == CH_UP_X))
                    begin
                        radix_next = RADIX_HEX;
                        phase_next = PH_PREFIX;
                    end
                    else if ((ch == CH_LO_B) || (ch == CH_UP_B))
                    begin
                        radix_next = RADIX_BIN;
                        phase_next = PH_PREFIX;
                    end
                    else
                        digit_path = 1'b1;
                end
                default:
                    digit_path = 1'b1;
            endcase

            if (digit_path)
            begin
                if (dig_ok)
                    phase_next = PH_DIGITS;
                else
                    bad_next = 1'b1;
            end
        end

        uop.digit_en = digit_path && dig_ok;
        uop.digit    = dig_val;
        uop.radix    = radix_reg;
        uop.last     = end_of_token;
        uop.shape_ok = !bad_next && ((phase_next == PH_ZERO) || (phase_next == PH_DIGITS));
        uop.negative = neg_next;
        uop_push     = accept && (uop.digit_en || end_of_token);

        // The token is over: everything returns to its start value.
        if (accept && end_of_token)
        begin
            phase_next = PH_START;
            radix_next = RADIX_DEC;
            neg_next   = 1'b0;
            bad_next   = 1'b0;
        end
    end

endmodule

// ===== hdl/atp_uop_queue.sv =====
module atp_uop_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  atp_pkg::uop_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          empty,
    output atp_pkg::uop_t rd_data
);
    import atp_pkg::*;

    uop_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        case ({do_wr, do_rd})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hdl/atp_back.sv =====
`include "assert_macros.svh"

module atp_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               uop_empty,
    input  atp_pkg::uop_t                      uop,
    output logic                               uop_pop,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [atp_pkg::MAG_W-1:0]   value,
    output logic                               valid_res
);
    import atp_pkg::*;

    // Accumulator
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             ovf_reg, ovf_next;
    logic [ACC_W-1:0] scaled;
    logic [ACC_W-1:0] wide;
    logic [MAG_W-1:0] mag_upd;
    logic             ovf_upd;
    logic             fire_a;

    // Finishing stage
    logic             fin_valid_reg, fin_valid_next;
    logic [MAG_W-1:0] fin_mag_reg;
    logic             fin_ovf_reg;
    logic             fin_shape_reg;
    logic             fin_neg_reg;
    logic             fin_ok;
    logic [MAG_W-1:0] fin_value;
    logic             fin_push;

    // Result queue, two entries
    logic [MAG_W-1:0] oq_val_reg [2];
    logic             oq_ok_reg  [2];
    logic             oq_wr_reg, oq_rd_reg;
    logic [1:0]       oq_cnt_reg, oq_cnt_next;
    logic             oq_pop;

    always_comb
    begin
        case (uop.radix)
            RADIX_HEX: scaled = {mag_reg, 4'b0000};
            RADIX_BIN: scaled = {3'b000, mag_reg, 1'b0};
            default:   scaled = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0};
        endcase
        wide = scaled + {{(ACC_W-4){1'b0}}, uop.digit};

        mag_upd = mag_reg;
        ovf_upd = ovf_reg;
        if (uop.digit_en && !ovf_reg)
        begin
            if (wide[ACC_W-1:MAG_W] != 4'd0)
                ovf_upd = 1'b1;
            else
                mag_upd = wide[MAG_W-1:0];
        end
    end

    assign fin_push = fin_valid_reg && (oq_cnt_reg != 2'd2);
    assign fire_a   = !uop_empty && (!uop.last || !fin_valid_reg || fin_push);
    assign uop_pop  = fire_a;

    always_comb
    begin
        mag_next = mag_reg;
        ovf_next = ovf_reg;
        if (fire_a)
        begin
            if (uop.last)
            begin
                mag_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                mag_next = mag_upd;
                ovf_next = ovf_upd;
            end
        end

        if (fire_a && uop.last)
            fin_valid_next = 1'b1;
        else if (fin_push)
            fin_valid_next = 1'b0;
        else
            fin_valid_next = fin_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            mag_reg       <= mag_next;
            ovf_reg       <= ovf_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_a && uop.last)
        begin
            fin_mag_reg   <= mag_upd;
            fin_ovf_reg   <= ovf_upd;
            fin_shape_reg <= uop.shape_ok;
            fin_neg_reg   <= uop.negative;
        end
    end

    // A negative magnitude may reach exactly the top bit; a positive one may not.
    always_comb
    begin
        fin_ok = fin_shape_reg && !fin_ovf_reg &&
                 (fin_neg_reg ? (fin_mag_reg <= MAG_TOP) : !fin_mag_reg[MAG_W-1]);
        if (!fin_ok)
            fin_value = '0;
        else if (fin_neg_reg)
            fin_value = '0 - fin_mag_reg;
        else
            fin_value = fin_mag_reg;
    end

    assign oq_pop    = pop && (oq_cnt_reg != 2'd0);
    assign empty     = (oq_cnt_reg == 2'd0);
    assign value     = oq_val_reg[oq_rd_reg];
    assign valid_res = oq_ok_reg[oq_rd_reg];

    always_comb
    begin
        case ({fin_push, oq_pop})
            2'b10:   oq_cnt_next = oq_cnt_reg + 2'd1;
            2'b01:   oq_cnt_next = oq_cnt_reg - 2'd1;
            default: oq_cnt_next = oq_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            oq_wr_reg  <= fin_push ? !oq_wr_reg : oq_wr_reg;
            oq_rd_reg  <= oq_pop ? !oq_rd_reg : oq_rd_reg;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_push)
        begin
            oq_val_reg[oq_wr_reg] <= fin_value;
            oq_ok_reg[oq_wr_reg]  <= fin_ok;
        end
    end

    `ATP_ASSERT_IMPLIES(a_oq_bound, clk, rst_n, 1'b1, oq_cnt_reg <= 2'd2)
    `ATP_ASSERT_NEXT(a_fin_load, clk, rst_n, fire_a && uop.last, fin_valid_reg)
    `ATP_ASSERT_NEXT(a_acc_clear, clk, rst_n, fire_a && uop.last, (mag_reg == '0) && !ovf_reg)
    `ATP_ASSERT_IMPLIES(a_bad_zero, clk, rst_n, fin_valid_reg && !fin_ok, fin_value == '0)

endmodule
